// ===== rtl/core/mbpe_pkg.sv =====
// Shared types and constants for the mono bitmap pixel expander.
`timescale 1ns / 1ps

package mbpe_pkg;

  // Display size defaults, in pixels
  localparam int DispColsDefault = 128;
  localparam int DispRowsDefault = 128;

  // Pixels carried by one bitmap byte
  localparam int PixPerByte = 8;

  // Entries in the queue between front and back end
  localparam int QueueDepth = 4;

  // Configuration port widths
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Output field widths
  localparam int CoordW = 7;
  localparam int ColorW = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_X      = 3'd0,
    CFG_START_Y      = 3'd1,
    CFG_IMAGE_WIDTH  = 3'd2,
    CFG_IMAGE_HEIGHT = 3'd3,
    CFG_DRAW_COLOR   = 3'd4
  } cfg_reg_t;

  // One classified byte: which of its pixels land on the display, and where
  typedef struct packed {
    logic [PixPerByte-1:0] mask;    // visible set bits, bit 0 leftmost
    logic [7:0]            x_base;  // display column of bit 0, wrapped to 8 bits
    logic [CoordW-1:0]     y;       // display row of the byte
    logic [ColorW-1:0]     color;   // draw colour at the time of the byte
  } entry_t;

endpackage

// ===== rtl/core/mbpe_front.sv =====
// Front end: configuration registers, row/column counters and byte classification.
`timescale 1ns / 1ps

module mbpe_front #(
  parameter int DISPLAY_COLUMNS = mbpe_pkg::DispColsDefault,
  parameter int DISPLAY_ROWS    = mbpe_pkg::DispRowsDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mbpe_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [mbpe_pkg::CfgDataW-1:0] cfg_data,
  input  logic                         byte_accept,
  input  logic [7:0]                   bitmap_byte,
  output mbpe_pkg::entry_t             entry,
  output logic                         entry_vld
);

  localparam logic [8:0] ColLimit = 9'(DISPLAY_COLUMNS);
  localparam logic [8:0] RowLimit = 9'(DISPLAY_ROWS);

  logic [7:0]  start_x_r, start_y_r, image_width_r, image_height_r;
  logic [15:0] draw_color_r;
  logic [4:0]  byte_column_r, byte_column_nxt;
  logic [7:0]  row_index_r, row_index_nxt;

  logic [5:0]  bytes_per_row;
  logic [7:0]  col_base;
  logic [7:0]  y_disp;
  logic        y_ok;
  logic [mbpe_pkg::PixPerByte-1:0] vis;
  logic [7:0]  lane_col [mbpe_pkg::PixPerByte];
  logic [7:0]  lane_x   [mbpe_pkg::PixPerByte];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r      <= 8'd0;
      start_y_r      <= 8'd0;
      image_width_r  <= 8'd8;
      image_height_r <= 8'd1;
      draw_color_r   <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (mbpe_pkg::cfg_reg_t'(cfg_index))
        mbpe_pkg::CFG_START_X:      start_x_r      <= cfg_data[7:0];
        mbpe_pkg::CFG_START_Y:      start_y_r      <= cfg_data[7:0];
        mbpe_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[7:0];
        mbpe_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[7:0];
        mbpe_pkg::CFG_DRAW_COLOR:   draw_color_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-lane visibility of the eight pixels of this byte
  always_comb begin
    bytes_per_row = 6'((({1'b0, image_width_r}) + 9'd7) >> 3);
    col_base      = {byte_column_r, 3'b000};
    y_disp        = start_y_r + row_index_r;
    y_ok          = {1'b0, y_disp} < RowLimit;
    for (int b = 0; b < mbpe_pkg::PixPerByte; b++) begin
      lane_col[b] = col_base | 8'(b);
      lane_x[b]   = start_x_r + lane_col[b];
      vis[b]      = bitmap_byte[b] && (lane_col[b] < image_width_r) &&
                    ({1'b0, lane_x[b]} < ColLimit) && y_ok;
    end
  end

  assign entry.mask   = vis;
  assign entry.x_base = start_x_r + col_base;
  assign entry.y      = y_disp[mbpe_pkg::CoordW-1:0];
  assign entry.color  = draw_color_r;
  // bytes with nothing visible only move the counters
  assign entry_vld    = byte_accept && (|vis);

  // Row and column counters
  always_comb begin
    byte_column_nxt = byte_column_r;
    row_index_nxt   = row_index_r;
    if (byte_accept) begin
      if (({1'b0, byte_column_r} + 6'd1) >= bytes_per_row) begin
        byte_column_nxt = 5'd0;
        if (({1'b0, row_index_r} + 9'd1) >= {1'b0, image_height_r}) begin
          row_index_nxt = 8'd0;
        end else begin
          row_index_nxt = row_index_r + 8'd1;
        end
      end else begin
        byte_column_nxt = byte_column_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_column_r <= 5'd0;
      row_index_r   <= 8'd0;
    end else begin
      byte_column_r <= byte_column_nxt;
      row_index_r   <= row_index_nxt;
    end
  end

endmodule

// ===== rtl/core/mbpe_queue.sv =====
// Short queue of classified bytes between front and back end.
`timescale 1ns / 1ps

module mbpe_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mbpe_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output mbpe_pkg::entry_t head,
  output logic             empty
);

  localparam int PtrW = $clog2(mbpe_pkg::QueueDepth);
  localparam int CntW = $clog2(mbpe_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] Depth = CntW'(mbpe_pkg::QueueDepth);

  mbpe_pkg::entry_t mem [mbpe_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]  count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == Depth);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(mbpe_pkg::QueueDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(mbpe_pkg::QueueDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/mbpe_back.sv =====
// Back end: walks the visible bits of a byte, one pixel beat per unstalled cycle.
`timescale 1ns / 1ps

module mbpe_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mbpe_pkg::entry_t            q_head,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [mbpe_pkg::CoordW-1:0] out_pixel_x,
  output logic [mbpe_pkg::CoordW-1:0] out_pixel_y,
  output logic [mbpe_pkg::ColorW-1:0] out_pixel_color,
  output logic                        out_last_of_byte
);

  localparam int IdxW = $clog2(mbpe_pkg::PixPerByte);

  logic [mbpe_pkg::PixPerByte-1:0] cur_mask_r, cur_mask_nxt;
  logic [7:0]                      cur_xb_r;
  logic [mbpe_pkg::CoordW-1:0]     cur_y_r;
  logic [mbpe_pkg::ColorW-1:0]     cur_color_r;
  logic                            out_vld_r;

  logic                            slot_free, emit, cur_done;
  logic [IdxW-1:0]                 idx;
  logic [mbpe_pkg::PixPerByte-1:0] rest;
  logic [7:0]                      x_full;

  // Lowest visible bit goes first (leftmost pixel)
  always_comb begin
    idx = '0;
    for (int b = mbpe_pkg::PixPerByte - 1; b >= 0; b--) begin
      if (cur_mask_r[b]) begin
        idx = IdxW'(b);
      end
    end
  end

  always_comb begin
    slot_free    = !out_vld_r || out_pop;
    emit         = slot_free && (|cur_mask_r);
    rest         = cur_mask_r & ~(mbpe_pkg::PixPerByte'(1) << idx);
    cur_done     = (cur_mask_r == '0) || (emit && (rest == '0));
    q_pop        = cur_done && !q_empty;
    x_full       = cur_xb_r + 8'(idx);
    cur_mask_nxt = cur_mask_r;
    if (q_pop) begin
      cur_mask_nxt = q_head.mask;
    end else if (emit) begin
      cur_mask_nxt = rest;
    end
  end

  // Byte being expanded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mask_r <= '0;
    end else begin
      cur_mask_r <= cur_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_xb_r    <= q_head.x_base;
      cur_y_r     <= q_head.y;
      cur_color_r <= q_head.color;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (out_pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel_x      <= x_full[mbpe_pkg::CoordW-1:0];
      out_pixel_y      <= cur_y_r;
      out_pixel_color  <= cur_color_r;
      out_last_of_byte <= (rest == '0);
    end
  end

  assign out_empty = !out_vld_r;

endmodule

// ===== rtl/core/mono_bitmap_pixel_expander.sv =====
// Top level of the mono bitmap pixel expander.
`timescale 1ns / 1ps

// Takes 1-bit-per-pixel bitmap bytes (row-major, rows padded to whole bytes,
// bit 0 leftmost) and issues one pixel write beat per visible set bit, left to
// right, with last_of_byte on the final beat of each byte. The front end
// classifies each byte it takes and updates the row/column counters, so
// bytes with no visible pixel give no beat and never enter the queue. Bytes
// with visible pixels wait in a four-entry queue; the back end then issues one
// pixel per cycle while the output is popped, up to 8 per byte, and
// back-to-back bytes stream with no gap between them. The output register lets
// a new byte enter while a pixel waits to be popped. Configuration writes are
// always ready and take effect on the next byte; write them only while no
// pixels are pending.
module mono_bitmap_pixel_expander #(
  parameter int DISPLAY_COLUMNS = mbpe_pkg::DispColsDefault,
  parameter int DISPLAY_ROWS    = mbpe_pkg::DispRowsDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbpe_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mbpe_pkg::CfgDataW-1:0] cfg_data,
  // bitmap bytes
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [7:0]                    in_bitmap_byte,
  // pixel writes
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [mbpe_pkg::CoordW-1:0]   out_pixel_x,
  output logic [mbpe_pkg::CoordW-1:0]   out_pixel_y,
  output logic [mbpe_pkg::ColorW-1:0]   out_pixel_color,
  output logic                          out_last_of_byte
);

  mbpe_pkg::entry_t f_entry, q_head;
  logic             f_entry_vld, q_full, q_empty, q_pop;
  logic             byte_accept;

  assign cfg_ready   = 1'b1;
  assign in_full     = q_full;
  assign byte_accept = in_push && !q_full;

  mbpe_front #(
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
    .DISPLAY_ROWS    (DISPLAY_ROWS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .byte_accept (byte_accept),
    .bitmap_byte (in_bitmap_byte),
    .entry       (f_entry),
    .entry_vld   (f_entry_vld)
  );

  mbpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_entry_vld),
    .push_entry (f_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  mbpe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_head           (q_head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_color  (out_pixel_color),
    .out_last_of_byte (out_last_of_byte)
  );

endmodule
